FILE: src/etsc_pkg.sv
// Shared types and constants for the edge toggle stream checker.
`default_nettype none

package etsc_pkg;

  // Update kinds carried on the input tuser.
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  // Node count register.
  localparam int unsigned NODE_COUNT_W   = 11;
  localparam logic [10:0] NODE_COUNT_RST = 11'd1024;

  // Bitmap memory row geometry.
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned WORD_OFF_W = 5;

  // Stream payload widths.
  localparam int unsigned NODE_ID_W = 32;
  localparam int unsigned IN_DATA_W = 64;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned OUT_DATA_W = 8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_READ,
    ST_FINISH
  } ctrl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic clear_en;
    logic capture;
    logic eval;
    logic read;
    logic finish;
  } etsc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_last;
    logic needs_mem;
    logic out_free;
  } etsc_stat_t;

endpackage

`default_nettype wire

FILE: src/edge_toggle_stream_checker_top.sv
// Top level of the edge toggle stream checker: stream ports, controller and datapath.
//
// Usage
//   Slave stream: one transaction is one edge update. s_axis_tuser is the update
//   kind (insert, delete, query; the unused code acts as a query), s_axis_tdata
//   carries the two endpoint ids. Master stream: one result transaction per update,
//   five flag bits in m_axis_tdata.
//   cfg_we_i / cfg_wdata_i write the node count; write only while the block is idle.
// Sequence
//   An insert or delete in range passes from acceptance through evaluate (row
//   start product), bitmap read and toggle write-back before the next acceptance.
//   A self-loop, query or out-of-range update skips the read. The result is
//   registered in the finish (write-back) step, and no new update is taken before
//   it; the single-port read-modify-write of the bitmap row is why updates do not overlap.
// Reset
//   Control state clears at once; the presence bitmap is then swept one 32-bit row
//   per cycle over all ceil(MAX_NODES*(MAX_NODES-1)/64) rows (16368 at 1024 nodes),
//   with s_axis_tready low. The node count returns to 1024, the sticky flag to 0.
// Backpressure
//   A result waits in the output register while m_axis_tready is low; the next
//   update is still accepted and worked on, and holds before write-back until the
//   output register is free.
`default_nettype none

module edge_toggle_stream_checker_top #(
  parameter int MAX_NODES = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Update stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // [31:0] src_node, [63:32] dst_node
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] update_kind
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] self_loop_error, [1] kind_error, [2] range_error, [3] expected_kind,
  // [4] error_seen, [7:5] zero
  output logic [7:0]       m_axis_tdata,
  // Node count register
  input  wire logic        cfg_we_i,
  input  wire logic [10:0] cfg_wdata_i
);

  etsc_pkg::etsc_cmd_t  cmd;
  etsc_pkg::etsc_stat_t stat;

  etsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  etsc_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_tready_i  (m_axis_tready),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire

FILE: src/etsc_ctrl.sv
// Sequencing state machine for the edge toggle stream checker.
`default_nettype none

module etsc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_tvalid_i,
  output logic                     s_tready_o,
  input  wire etsc_pkg::etsc_stat_t stat_i,
  output etsc_pkg::etsc_cmd_t      cmd_o
);

  etsc_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= etsc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      etsc_pkg::ST_CLEAR: begin
        if (stat_i.clear_last) state_d = etsc_pkg::ST_IDLE;
      end
      etsc_pkg::ST_IDLE: begin
        if (s_tvalid_i) state_d = etsc_pkg::ST_EVAL;
      end
      etsc_pkg::ST_EVAL: begin
        state_d = stat_i.needs_mem ? etsc_pkg::ST_READ : etsc_pkg::ST_FINISH;
      end
      etsc_pkg::ST_READ: begin
        state_d = etsc_pkg::ST_FINISH;
      end
      etsc_pkg::ST_FINISH: begin
        if (stat_i.out_free) state_d = etsc_pkg::ST_IDLE;
      end
      default: begin
        state_d = etsc_pkg::ST_CLEAR;
      end
    endcase
  end

  // Outputs
  always_comb begin
    s_tready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      etsc_pkg::ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
      end
      etsc_pkg::ST_IDLE: begin
        s_tready_o    = 1'b1;
        cmd_o.capture = s_tvalid_i;
      end
      etsc_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
      end
      etsc_pkg::ST_READ: begin
        cmd_o.read = 1'b1;
      end
      etsc_pkg::ST_FINISH: begin
        cmd_o.finish = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // No transaction is taken while the bitmap is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == etsc_pkg::ST_CLEAR) |-> !s_tready_o)
    else $error("input ready during bitmap clear");

  // A blocked finish waits for the output register.
  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == etsc_pkg::ST_FINISH && !stat_i.out_free) |=>
      (state_q == etsc_pkg::ST_FINISH))
    else $error("finish left while output register full");

  // A bitmap read is only entered from evaluation.
  a_read_after_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == etsc_pkg::ST_READ) |-> ($past(state_q) == etsc_pkg::ST_EVAL))
    else $error("bitmap read without evaluation");

endmodule

`default_nettype wire

FILE: src/etsc_datapath.sv
// Checks, pair index arithmetic, presence bitmap and result register.
`default_nettype none

module etsc_datapath #(
  parameter int MAX_NODES = 1024
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire etsc_pkg::etsc_cmd_t                   cmd_i,
  output etsc_pkg::etsc_stat_t                       stat_o,
  input  wire logic [etsc_pkg::IN_DATA_W-1:0]        s_tdata_i,
  input  wire logic [etsc_pkg::KIND_W-1:0]           s_tuser_i,
  input  wire logic                                  cfg_we_i,
  input  wire logic [etsc_pkg::NODE_COUNT_W-1:0]     cfg_wdata_i,
  input  wire logic                                  m_tready_i,
  output logic                                       m_tvalid_o,
  output logic [etsc_pkg::OUT_DATA_W-1:0]            m_tdata_o
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam longint unsigned PAIR_COUNT =
    (longint'(MAX_NODES) * longint'(MAX_NODES - 1)) / 2;
  localparam int ROWS =
    int'((PAIR_COUNT + longint'(etsc_pkg::WORD_BITS) - 1) / longint'(etsc_pkg::WORD_BITS));
  localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W  = ADDR_W + etsc_pkg::WORD_OFF_W;
  localparam int LIM_W  = ($clog2(MAX_NODES + 1) > etsc_pkg::NODE_COUNT_W) ?
                          $clog2(MAX_NODES + 1) : etsc_pkg::NODE_COUNT_W;
  localparam int PROD_W = 2 * NODE_W + 1;
  localparam int WB     = etsc_pkg::WORD_BITS;
  localparam int OW     = etsc_pkg::WORD_OFF_W;
  localparam int IDW    = etsc_pkg::NODE_ID_W;

  // Config register
  logic [etsc_pkg::NODE_COUNT_W-1:0] node_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= etsc_pkg::NODE_COUNT_RST;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  logic [LIM_W-1:0] limit;
  assign limit = (LIM_W'(node_count_q) > LIM_W'(MAX_NODES)) ?
                 LIM_W'(MAX_NODES) : LIM_W'(node_count_q);

  // Captured transaction
  logic [IDW-1:0]               src_q, dst_q;
  logic [etsc_pkg::KIND_W-1:0]  kind_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      src_q  <= s_tdata_i[IDW-1:0];
      dst_q  <= s_tdata_i[2*IDW-1:IDW];
      kind_q <= s_tuser_i;
    end
  end

  // Evaluation: error checks, endpoint ordering, row start product
  logic self_c, is_upd_c, range_c, needs_c, src_lt_dst;
  logic [NODE_W-1:0] lo_c, hi_c;

  assign self_c     = (src_q == dst_q);
  assign is_upd_c   = (kind_q == etsc_pkg::KIND_INSERT) || (kind_q == etsc_pkg::KIND_DELETE);
  assign range_c    = !self_c && is_upd_c &&
                      ((src_q >= IDW'(limit)) || (dst_q >= IDW'(limit)));
  assign needs_c    = !self_c && is_upd_c && !range_c;
  assign src_lt_dst = (src_q < dst_q);
  assign lo_c       = src_lt_dst ? src_q[NODE_W-1:0] : dst_q[NODE_W-1:0];
  assign hi_c       = src_lt_dst ? dst_q[NODE_W-1:0] : src_q[NODE_W-1:0];

  logic              self_q, range_q, needs_q;
  logic [PROD_W-1:0] prod_q;
  logic [IDX_W-1:0]  diff_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      self_q  <= self_c;
      range_q <= range_c;
      needs_q <= needs_c;
      // lo * (2N - 1 - lo) is always even
      prod_q  <= PROD_W'(lo_c) * (PROD_W'(2 * MAX_NODES - 1) - PROD_W'(lo_c));
      diff_q  <= IDX_W'(NODE_W'(hi_c - lo_c - NODE_W'(1)));
    end
  end

  // Bitmap read
  logic [IDX_W-1:0] idx_c, idx_q;
  logic [WB-1:0]    rdata_q;
  logic [WB-1:0]    mem [ROWS];

  assign idx_c = IDX_W'(prod_q >> 1) + diff_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      idx_q   <= idx_c;
      rdata_q <= mem[idx_c[IDX_W-1:OW]];
    end
  end

  // Bitmap write port: clearing pass or toggle
  logic [ADDR_W-1:0] clr_cnt_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WB-1:0]     mem_wdata;
  logic              cur_bit;

  assign cur_bit   = rdata_q[idx_q[OW-1:0]];
  assign mem_we    = cmd_i.clear_en || (cmd_i.finish && needs_q);
  assign mem_waddr = cmd_i.clear_en ? clr_cnt_q : idx_q[IDX_W-1:OW];
  assign mem_wdata = cmd_i.clear_en ? '0 : (rdata_q ^ (WB'(1) << idx_q[OW-1:0]));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_en) begin
      clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
    end
  end

  // Result register and sticky flag
  logic kind_err_c, expected_c, any_err_c;
  logic out_valid_q, sticky_q;
  logic self_err_q, kind_err_q, range_err_q, expected_q, error_seen_q;

  assign expected_c = needs_q && cur_bit;
  assign kind_err_c = needs_q && (cur_bit != kind_q[0]);
  assign any_err_c  = self_q || kind_err_c || range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sticky_q    <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        sticky_q    <= sticky_q || any_err_c;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      self_err_q   <= self_q;
      kind_err_q   <= kind_err_c;
      range_err_q  <= range_q;
      expected_q   <= expected_c;
      error_seen_q <= sticky_q || any_err_c;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {3'b000, error_seen_q, expected_q, range_err_q, kind_err_q, self_err_q};

  assign stat_o.clear_last = (clr_cnt_q == ADDR_W'(ROWS - 1));
  assign stat_o.needs_mem  = needs_c;
  assign stat_o.out_free   = !out_valid_q || m_tready_i;

  a_sticky_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sticky_q |=> sticky_q)
    else $error("sticky error flag dropped");

  a_kind_err_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_err_q) |-> (!self_err_q && !range_err_q))
    else $error("kind error together with self-loop or range error");

  a_err_implies_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (self_err_q || kind_err_q || range_err_q)) |-> error_seen_q)
    else $error("error result without error_seen");

  a_clear_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_en |-> (!cmd_i.read && !cmd_i.finish))
    else $error("bitmap access during clearing pass");

endmodule

`default_nettype wire

FILE: dv/edge_toggle_stream_checker_top_tb.sv
// Self-checking testbench for the edge toggle stream checker: edge updates in, result flags out.
module edge_toggle_stream_checker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_NODES      = 1024;
  localparam int unsigned PAIR_TOTAL     = MAX_NODES * (MAX_NODES - 1) / 2;
  localparam logic [1:0]  KIND_UNUSED    = 2'd3;
  // Two copies of the edge state: one follows accepted transactions, the other
  // follows generation so the generator knows which kind is the correct one.
  localparam int          LIVE           = 0;
  localparam int          PLANNED        = 1;
  localparam int          SETTLE_CYCLES  = 8;      // wait after both queues have drained
  localparam int          DRAIN_LIMIT    = 2000;
  // The bitmap sweep after reset holds s_axis_tready low; the watchdog limit covers it.
  localparam int          WATCHDOG_LIMIT = 60000;
  localparam int          PRINT_LIMIT    = 40;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] dst;
    logic [31:0] src;
  } update_t;

  // Same bit order as m_axis_tdata.
  typedef struct packed {
    logic [2:0] pad;
    logic       error_seen;
    logic       expected_kind;
    logic       range_err;
    logic       kind_err;
    logic       self_loop;
  } flags_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = etsc_pkg::KIND_INSERT;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [10:0] cfg_wdata_i   = etsc_pkg::NODE_COUNT_RST;

  edge_toggle_stream_checker_top #(
    .MAX_NODES(MAX_NODES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Predictor state
  bit          pair_map [2][PAIR_TOTAL];
  bit          sticky_seen [2];
  logic [10:0] node_limit = etsc_pkg::NODE_COUNT_RST;

  update_t     pending_updates[$];
  flags_t      awaited_flags[$];

  bit          took_update;
  bit          calm;
  bit          send_gaps  = 1'b1;
  bit          recv_stalls = 1'b1;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned quiet_cycles;
  int unsigned mismatch_count;
  int unsigned updates_sent;
  int unsigned results_seen;
  int unsigned settings_written;
  int unsigned self_loop_hits, kind_err_hits, range_err_hits;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pair_slot(int unsigned lo, int unsigned hi);
    return lo * (2 * MAX_NODES - lo - 1) / 2 + hi - lo - 1;
  endfunction

  function automatic int unsigned active_limit();
    return (node_limit > MAX_NODES) ? MAX_NODES : node_limit;
  endfunction

  // Works out the result flags of one update and applies it to one state copy.
  function automatic flags_t predict_flags(int copy, update_t u);
    flags_t      f;
    int unsigned lim;
    int unsigned slot;
    f   = '0;
    lim = active_limit();
    if (u.src == u.dst) begin
      f.self_loop = 1'b1;
    end else if (u.kind == etsc_pkg::KIND_INSERT || u.kind == etsc_pkg::KIND_DELETE) begin
      if (u.src >= lim || u.dst >= lim) begin
        f.range_err = 1'b1;
      end else begin
        slot = (u.src < u.dst) ? pair_slot(u.src, u.dst) : pair_slot(u.dst, u.src);
        f.expected_kind = pair_map[copy][slot];
        f.kind_err      = (pair_map[copy][slot] != u.kind[0]);
        pair_map[copy][slot] = !pair_map[copy][slot];
      end
    end
    if (f.self_loop || f.kind_err || f.range_err) sticky_seen[copy] = 1'b1;
    f.error_seen = sticky_seen[copy];
    return f;
  endfunction

  function automatic void queue_update(logic [1:0] kind, logic [31:0] src, logic [31:0] dst);
    update_t u;
    u.kind = kind;
    u.src  = src;
    u.dst  = dst;
    void'(predict_flags(PLANNED, u));
    pending_updates.push_back(u);
  endfunction

  // Mostly well-formed toggles on a small vertex set so pairs come back often;
  // the rest is queries, self-loops, out-of-range ids and full-width noise.
  function automatic void queue_random(int unsigned span);
    update_t     u;
    int unsigned lim, top, lo, hi, pick;
    logic        present;
    lim    = active_limit();
    top    = (span < lim) ? span : lim;
    pick   = $urandom_range(0, 99);
    u.src  = $urandom;
    u.dst  = $urandom;
    u.kind = 2'($urandom_range(0, 3));
    if (pick < 70 && top >= 2) begin
      lo = $urandom_range(0, top - 2);
      hi = $urandom_range(lo + 1, top - 1);
      if ($urandom_range(0, 7) == 0) hi = lim - 1;
      present = pair_map[PLANNED][pair_slot(lo, hi)];
      // one in ten asks for the wrong kind
      u.kind  = {1'b0, present ^ ($urandom_range(0, 9) == 0)};
      if ($urandom_range(0, 1)) begin
        u.src = lo;
        u.dst = hi;
      end else begin
        u.src = hi;
        u.dst = lo;
      end
    end else if (pick < 78) begin
      u.kind = $urandom_range(0, 1) ? etsc_pkg::KIND_QUERY : KIND_UNUSED;
      if ($urandom_range(0, 1)) begin
        u.src = $urandom_range(0, 63);
        u.dst = $urandom_range(0, 63);
      end
    end else if (pick < 86) begin
      if ($urandom_range(0, 1)) u.src = $urandom_range(0, 1100);
      u.dst = u.src;
    end else if (pick < 94) begin
      u.kind = {1'b0, 1'($urandom_range(0, 1))};
      u.src  = $urandom_range(0, 1) ? $urandom_range(lim, lim + 1100) : $urandom;
      u.dst  = (lim == 0) ? 0 : $urandom_range(0, lim - 1);
      if ($urandom_range(0, 1)) {u.src, u.dst} = {u.dst, u.src};
    end
    queue_update(u.kind, u.src, u.dst);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t: result %0d %s: got %0h, want %0h", $realtime, results_seen, what, got,
               want);
    mismatch_count++;
  endtask

  // Waits until every queued update has gone in and every result has come out.
  task automatic wait_drained();
    while (pending_updates.size() != 0 || awaited_flags.size() != 0 || s_axis_tvalid)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_node_count(logic [10:0] count);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    node_limit   = count;
    settings_written++;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(logic [10:0] count, int unsigned items, int unsigned span);
    wait_drained();
    write_node_count(count);
    repeat (items) queue_random(span);
  endtask

  // Update driver: holds a transaction until taken, random gap bursts in between.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || took_update)) begin
      took_update = 1'b0;
      if ($urandom_range(0, 47) == 0) send_gaps = !send_gaps;
      if (send_gap == 0 && send_gaps && !calm && $urandom_range(0, 9) == 0)
        send_gap = $urandom_range(1, 15);
      if (send_gap != 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_updates.size() != 0) begin
        s_axis_tdata  <= {pending_updates[0].dst, pending_updates[0].src};
        s_axis_tuser  <= pending_updates[0].kind;
        s_axis_tvalid <= 1'b1;
        void'(pending_updates.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result side backpressure.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 63) == 0) recv_stalls = !recv_stalls;
      if (stall_left == 0 && recv_stalls && !calm && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 15);
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on every accepted update, checks every accepted result.
  always @(posedge clk_i) begin
    update_t u;
    flags_t  got, want;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      u.kind = s_axis_tuser;
      u.src  = s_axis_tdata[31:0];
      u.dst  = s_axis_tdata[63:32];
      awaited_flags.push_back(predict_flags(LIVE, u));
      took_update = 1'b1;
      updates_sent++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = flags_t'(m_axis_tdata);
      self_loop_hits += got.self_loop;
      kind_err_hits  += got.kind_err;
      range_err_hits += got.range_err;
      if (awaited_flags.size() == 0) begin
        report_mismatch("result with nothing pending", got, 0);
      end else begin
        want = awaited_flags.pop_front();
        if (got.self_loop != want.self_loop)
          report_mismatch("self_loop_error", got.self_loop, want.self_loop);
        if (got.kind_err != want.kind_err)
          report_mismatch("kind_error", got.kind_err, want.kind_err);
        if (got.range_err != want.range_err)
          report_mismatch("range_error", got.range_err, want.range_err);
        if (got.expected_kind != want.expected_kind)
          report_mismatch("expected_kind", got.expected_kind, want.expected_kind);
        if (got.error_seen != want.error_seen)
          report_mismatch("error_seen", got.error_seen, want.error_seen);
        if (got.pad != want.pad)
          report_mismatch("padding bits", got.pad, want.pad);
      end
      results_seen++;
    end
    // watchdog: cycles without any transaction on either stream
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("edge_toggle_stream_checker_top_tb failed");
      $finish;
    end
  end

  initial begin
    int unsigned waited;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // bitmap sweep runs with s_axis_tready low
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);

    // Directed: ordering of endpoints, wrong kinds both ways, corner vertices,
    // self-loops of every kind, queries, unused kind, out-of-range ids.
    write_node_count(11'd1024);
    queue_update(etsc_pkg::KIND_INSERT, 32'd0, 32'd1);
    queue_update(etsc_pkg::KIND_QUERY,  32'd0, 32'd1);
    queue_update(etsc_pkg::KIND_INSERT, 32'd1, 32'd0);
    queue_update(etsc_pkg::KIND_DELETE, 32'd0, 32'd1);
    queue_update(etsc_pkg::KIND_DELETE, 32'd1, 32'd0);
    queue_update(etsc_pkg::KIND_INSERT, 32'd1022, 32'd1023);
    queue_update(etsc_pkg::KIND_DELETE, 32'd1023, 32'd1022);
    queue_update(etsc_pkg::KIND_INSERT, 32'd0, 32'd1023);
    queue_update(etsc_pkg::KIND_INSERT, 32'd1023, 32'd0);
    queue_update(etsc_pkg::KIND_INSERT, 32'd5, 32'd5);
    queue_update(etsc_pkg::KIND_DELETE, 32'd5, 32'd5);
    queue_update(etsc_pkg::KIND_QUERY,  32'd5, 32'd5);
    queue_update(KIND_UNUSED, 32'd5, 32'd5);
    queue_update(etsc_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_update(KIND_UNUSED, 32'd3, 32'd7);
    queue_update(etsc_pkg::KIND_INSERT, 32'd1024, 32'd0);
    queue_update(etsc_pkg::KIND_DELETE, 32'd0, 32'd1024);
    queue_update(etsc_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'd0);
    queue_update(etsc_pkg::KIND_DELETE, 32'd0, 32'hFFFF_FFFF);
    queue_update(etsc_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    queue_update(etsc_pkg::KIND_QUERY,  32'hFFFF_FFFF, 32'd0);
    queue_update(KIND_UNUSED, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_update(etsc_pkg::KIND_DELETE, 32'd1, 32'd2);
    repeat (300) queue_random(12);

    // node_count sweep: empty graph, single vertex, one pair, saturated values, a random small count, full size
    run_phase(11'd0, 60, 8);
    run_phase(11'd1, 60, 8);
    run_phase(11'd2, 100, 8);
    run_phase(11'd2047, 300, 24);
    run_phase(11'd1025, 150, 16);
    run_phase(11'($urandom_range(3, 64)), 300, 10);
    wait_drained();
    calm = 1'b1;
    run_phase(11'd1024, 380, 20);

    while (pending_updates.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    waited = 0;
    while (awaited_flags.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (awaited_flags.size() != 0)
      report_mismatch("results never delivered", awaited_flags.size(), 0);

    $display("Covered %0d updates and %0d results over %0d node_count settings.",
             updates_sent, results_seen, settings_written);
    $display("Flags raised: self-loop %0d, kind %0d, range %0d; mismatches %0d.",
             self_loop_hits, kind_err_hits, range_err_hits, mismatch_count);
    if (mismatch_count == 0)
      $display("edge_toggle_stream_checker_top_tb passed");
    else
      $display("edge_toggle_stream_checker_top_tb failed");
    $finish;
  end

endmodule

FILE: filelist.f
src/etsc_pkg.sv
src/etsc_ctrl.sv
src/etsc_datapath.sv
src/edge_toggle_stream_checker_top.sv
dv/edge_toggle_stream_checker_top_tb.sv
